// ----- src/pcr_pkg.sv -----
`default_nettype none

package pcr_pkg;

  // Vector and field geometry
  localparam int COMPONENT_BITS = 21;
  localparam int CB    = COMPONENT_BITS;
  localparam int FB    = 10;
  localparam int VW    = 3 * CB;
  localparam int OVW   = 63;
  localparam int IMW   = 24;
  localparam int TOTW  = IMW + 1;
  localparam int PENW  = 21;
  localparam int RW    = 17;
  localparam int TSW   = 16;
  localparam logic [TSW-1:0] TS_RESET = 16'd1092;

  // Arithmetic widths
  localparam int SW    = 2 * CB + 3;
  localparam int TW    = 64;
  localparam int DVW   = 2 * CB - 7;
  localparam int QW    = (DVW > PENW - 1) ? DVW : PENW - 1;
  localparam int DIVW  = QW + IMW;
  localparam int PW    = QW + 1 + CB;
  localparam int NL    = 4;

  // Divider lanes
  localparam int LN_S1 = 0;
  localparam int LN_S2 = 1;
  localparam int LN_M1 = 2;
  localparam int LN_M2 = 3;

  typedef struct packed {
    logic [VW-1:0] v1;
    logic [VW-1:0] v2;
    logic [VW-1:0] p1;
    logic [VW-1:0] p2;
    logic [VW-1:0] n;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    logic va;
    logic pa;
  } side_t;

  localparam logic signed [PW:0] SAT_HI = (PW+1)'((1 << (CB - 1)) - 1);
  localparam logic signed [PW:0] SAT_LO = -SAT_HI - (PW+1)'(1);

  // Sign-extended component, one bit wider
  function automatic logic signed [CB:0] sx(input logic [VW-1:0] w, input int i);
    logic [CB-1:0] c;
    c = w[i*CB +: CB];
    return $signed({c[CB-1], c});
  endfunction

  // Component as is
  function automatic logic signed [CB-1:0] sn(input logic [VW-1:0] w, input int i);
    return $signed(w[i*CB +: CB]);
  endfunction

  // Clamp to the component range
  function automatic logic [CB-1:0] sat_c(input logic signed [PW:0] x);
    logic signed [PW:0] y;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end else begin
      y = x;
    end
    return y[CB-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/pcr_div.sv -----
`default_nettype none

module pcr_div
  import pcr_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic            valid_i,
  input  wire logic [DIVW-1:0] dvd_i [NL],
  input  wire logic [TOTW-1:0] dsr_i,
  input  wire side_t           side_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quo_o [NL],
  output side_t                side_o
);

  logic [TOTW-1:0] rem_q [QW+1][NL];
  logic [TOTW-1:0] rem_d [QW+1][NL];
  logic [QW-1:0]   qd_q  [QW+1][NL];
  logic [QW-1:0]   qd_d  [QW+1][NL];
  logic [TOTW-1:0] dsr_q [QW+1];
  side_t           side_q [QW+1];
  logic [QW:0]     vld_q;

  // Load the upper dividend bits as remainder, then one quotient bit per stage
  always_comb begin
    logic [TOTW:0] t;
    logic ge;
    t  = '0;
    ge = 1'b0;
    for (int l = 0; l < NL; l++) begin
      rem_d[0][l] = TOTW'(dvd_i[l][DIVW-1:QW]);
      qd_d[0][l]  = dvd_i[l][QW-1:0];
    end
    for (int k = 1; k <= QW; k++) begin
      for (int l = 0; l < NL; l++) begin
        t  = {rem_q[k-1][l], qd_q[k-1][l][QW-1]};
        ge = t >= {1'b0, dsr_q[k-1]};
        rem_d[k][l] = ge ? TOTW'(t - {1'b0, dsr_q[k-1]}) : t[TOTW-1:0];
        qd_d[k][l]  = {qd_q[k-1][l][QW-2:0], ge};
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k <= QW; k++) begin
        rem_q[k] <= rem_d[k];
        qd_q[k]  <= qd_d[k];
      end
      dsr_q[0]  <= dsr_i;
      side_q[0] <= side_i;
      for (int k = 1; k <= QW; k++) begin
        dsr_q[k]  <= dsr_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = qd_q[QW];
  assign side_o  = side_q[QW];

endmodule

`default_nettype wire

// ----- src/particle_contact_resolver_top.sv -----
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   vel, acc, pos, normal, masses, pen, rest
// out       output     out_valid_o / out_stall_i new velocities, positions, applied flags
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i -> time_step
//
// One contact enters per cycle while in_stall_o is low; its result passes, at the default component width,
// through 7 arithmetic stages, a 36-stage restoring divider that loads the dividends and then
// forms one quotient bit per stage, 2 apply stages and the output reg.
// Reset clears all valid bits and loads time_step with 1092.
// The pipeline holds as a whole only when its last stage and the output register are both
// full; an empty last stage lets it advance, so input is taken while a result waits.

module particle_contact_resolver_top
  import pcr_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [TSW-1:0]          cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [OVW-1:0]          vel_first_i,
  input  wire logic [OVW-1:0]          vel_second_i,
  input  wire logic [OVW-1:0]          acc_first_i,
  input  wire logic [OVW-1:0]          acc_second_i,
  input  wire logic [OVW-1:0]          pos_first_i,
  input  wire logic [OVW-1:0]          pos_second_i,
  input  wire logic [OVW-1:0]          normal_i,
  input  wire logic [IMW-1:0]          inv_mass_first_i,
  input  wire logic [IMW-1:0]          inv_mass_second_i,
  input  wire logic signed [PENW-1:0]  penetration_i,
  input  wire logic [RW-1:0]           restitution_i,
  input  wire logic                    has_second_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [OVW-1:0]               new_vel_first_o,
  output logic [OVW-1:0]               new_vel_second_o,
  output logic [OVW-1:0]               new_pos_first_o,
  output logic [OVW-1:0]               new_pos_second_o,
  output logic                         velocity_applied_o,
  output logic                         position_applied_o
);

  logic adv;
  logic [TSW-1:0] ts_q;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TS_RESET;
    end else if (cfg_valid_i) begin
      ts_q <= cfg_data_i;
    end
  end

  // ---------------- Stage A: relative velocity and acceleration
  logic a_vld_q;
  ctx_t a_ctx_q, a_ctx_d;
  logic signed [CB:0] a_rv_q [3], a_rv_d [3], a_ra_q [3], a_ra_d [3];
  logic [IMW-1:0] a_im1_q, a_im2_q;
  logic signed [PENW-1:0] a_pen_q;
  logic [RW-1:0] a_r_q;

  always_comb begin
    a_ctx_d.v1 = vel_first_i[VW-1:0];
    a_ctx_d.v2 = vel_second_i[VW-1:0];
    a_ctx_d.p1 = pos_first_i[VW-1:0];
    a_ctx_d.p2 = pos_second_i[VW-1:0];
    a_ctx_d.n  = normal_i[VW-1:0];
    for (int i = 0; i < 3; i++) begin
      a_rv_d[i] = sx(vel_first_i[VW-1:0], i)
                - (has_second_i ? sx(vel_second_i[VW-1:0], i) : '0);
      a_ra_d[i] = sx(acc_first_i[VW-1:0], i)
                - (has_second_i ? sx(acc_second_i[VW-1:0], i) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ctx_q <= a_ctx_d;
      a_rv_q  <= a_rv_d;
      a_ra_q  <= a_ra_d;
      a_im1_q <= inv_mass_first_i;
      a_im2_q <= has_second_i ? inv_mass_second_i : '0;
      a_pen_q <= penetration_i;
      a_r_q   <= restitution_i;
    end
  end

  // ---------------- Stage B: per-component products with the normal
  logic b_vld_q;
  ctx_t b_ctx_q;
  logic signed [2*CB:0] b_sp_q [3], b_ap_q [3];
  logic [IMW-1:0] b_im1_q, b_im2_q;
  logic signed [PENW-1:0] b_pen_q;
  logic [RW-1:0] b_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_sp_q[i] <= a_rv_q[i] * sn(a_ctx_q.n, i);
        b_ap_q[i] <= a_ra_q[i] * sn(a_ctx_q.n, i);
      end
      b_ctx_q <= a_ctx_q;
      b_im1_q <= a_im1_q;
      b_im2_q <= a_im2_q;
      b_pen_q <= a_pen_q;
      b_r_q   <= a_r_q;
    end
  end

  // ---------------- Stage C: dot products and total inverse mass
  logic c_vld_q;
  ctx_t c_ctx_q;
  logic signed [SW-1:0] c_sep_q, c_accd_q;
  logic [TOTW-1:0] c_tot_q;
  logic [IMW-1:0] c_im1_q, c_im2_q;
  logic signed [PENW-1:0] c_pen_q;
  logic [RW-1:0] c_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_sep_q  <= SW'(b_sp_q[0]) + SW'(b_sp_q[1]) + SW'(b_sp_q[2]);
      c_accd_q <= SW'(b_ap_q[0]) + SW'(b_ap_q[1]) + SW'(b_ap_q[2]);
      c_tot_q  <= TOTW'(b_im1_q) + TOTW'(b_im2_q);
      c_ctx_q  <= b_ctx_q;
      c_im1_q  <= b_im1_q;
      c_im2_q  <= b_im2_q;
      c_pen_q  <= b_pen_q;
      c_r_q    <= b_r_q;
    end
  end

  // ---------------- Stage D: acceleration term and bounce target
  logic d_vld_q;
  ctx_t d_ctx_q;
  logic signed [TW-1:0] d_accp_q, d_tgt0_q, d_sep_q;
  logic [TOTW-1:0] d_tot_q;
  logic [IMW-1:0] d_im1_q, d_im2_q;
  logic signed [PENW-1:0] d_pen_q;
  logic [RW-1:0] d_r_q;
  logic d_va_q, d_pa_q;
  logic signed [TW-1:0] d_sep_w;

  assign d_sep_w = TW'(c_sep_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_accp_q <= TW'(c_accd_q) * $signed({1'b0, ts_q});
      d_tgt0_q <= -(d_sep_w * $signed({1'b0, c_r_q}));
      d_sep_q  <= d_sep_w;
      d_va_q   <= (c_sep_q < 0) && (c_tot_q != '0);
      d_pa_q   <= (c_pen_q > 0) && (c_tot_q != '0);
      d_ctx_q  <= c_ctx_q;
      d_tot_q  <= c_tot_q;
      d_im1_q  <= c_im1_q;
      d_im2_q  <= c_im2_q;
      d_pen_q  <= c_pen_q;
      d_r_q    <= c_r_q;
    end
  end

  // ---------------- Stage E: floor acceleration term and scale by restitution
  logic e_vld_q;
  ctx_t e_ctx_q;
  logic signed [TW-1:0] e_racc_q, e_tgt0_q, e_sep_q, e_acc20;
  logic e_neg_q;
  logic [TOTW-1:0] e_tot_q;
  logic [IMW-1:0] e_im1_q, e_im2_q;
  logic signed [PENW-1:0] e_pen_q;
  logic e_va_q, e_pa_q;

  assign e_acc20 = d_accp_q >>> TSW;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_racc_q <= e_acc20 * $signed({1'b0, d_r_q});
      e_neg_q  <= e_acc20[TW-1];
      e_tgt0_q <= d_tgt0_q;
      e_sep_q  <= d_sep_q;
      e_ctx_q  <= d_ctx_q;
      e_tot_q  <= d_tot_q;
      e_im1_q  <= d_im1_q;
      e_im2_q  <= d_im2_q;
      e_pen_q  <= d_pen_q;
      e_va_q   <= d_va_q;
      e_pa_q   <= d_pa_q;
    end
  end

  // ---------------- Stage F: clamp target at zero
  logic f_vld_q;
  ctx_t f_ctx_q;
  logic signed [TW-1:0] f_tgt_q, f_sep_q, f_sum;
  logic [TOTW-1:0] f_tot_q;
  logic [IMW-1:0] f_im1_q, f_im2_q;
  logic signed [PENW-1:0] f_pen_q;
  logic f_va_q, f_pa_q;

  assign f_sum = e_tgt0_q + e_racc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_tgt_q <= e_neg_q ? ((f_sum < 0) ? '0 : f_sum) : e_tgt0_q;
      f_sep_q <= e_sep_q;
      f_ctx_q <= e_ctx_q;
      f_tot_q <= e_tot_q;
      f_im1_q <= e_im1_q;
      f_im2_q <= e_im2_q;
      f_pen_q <= e_pen_q;
      f_va_q  <= e_va_q;
      f_pa_q  <= e_pa_q;
    end
  end

  // ---------------- Stage G: velocity change, floored to 10 fraction bits
  logic g_vld_q;
  ctx_t g_ctx_q;
  logic signed [TW-1:0] g_dv36;
  logic [DVW-1:0] g_dv_q;
  logic [TOTW-1:0] g_tot_q;
  logic [IMW-1:0] g_im1_q, g_im2_q;
  logic signed [PENW-1:0] g_pen_q;
  logic g_va_q, g_pa_q;

  assign g_dv36 = f_tgt_q - (f_sep_q <<< 16);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_dv_q  <= g_dv36[DVW+25:26];
      g_ctx_q <= f_ctx_q;
      g_tot_q <= f_tot_q;
      g_im1_q <= f_im1_q;
      g_im2_q <= f_im2_q;
      g_pen_q <= f_pen_q;
      g_va_q  <= f_va_q;
      g_pa_q  <= f_pa_q;
    end
  end

  // ---------------- Stage H: dividends, registered as the divider's first stage
  logic [DIVW-1:0] h_dvd [NL];
  side_t h_side;
  logic [PENW-2:0] h_pen;

  assign h_pen = g_pen_q[PENW-2:0];

  always_comb begin
    h_dvd[LN_S1] = DIVW'(g_dv_q * g_im1_q);
    h_dvd[LN_S2] = DIVW'(g_dv_q * g_im2_q);
    h_dvd[LN_M1] = DIVW'(h_pen * g_im1_q);
    h_dvd[LN_M2] = DIVW'(h_pen * g_im2_q);
    h_side.ctx   = g_ctx_q;
    h_side.va    = g_va_q;
    h_side.pa    = g_pa_q;
  end

  logic div_vld;
  logic [QW-1:0] div_quo [NL];
  side_t div_side;

  pcr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (g_vld_q),
    .dvd_i   (h_dvd),
    .dsr_i   (g_tot_q),
    .side_i  (h_side),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // ---------------- Stage I: shares times normal
  logic i_vld_q;
  side_t i_side_q;
  logic signed [PW-1:0] i_prod_q [NL][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) begin
        for (int i = 0; i < 3; i++) begin
          i_prod_q[l][i] <= $signed({1'b0, div_quo[l]}) * sn(div_side.ctx.n, i);
        end
      end
      i_side_q <= div_side;
    end
  end

  // ---------------- Stage J: apply moves and saturate
  logic j_vld_q;
  logic [VW-1:0] j_vec_q [NL], j_vec_d [NL];
  logic j_va_q, j_pa_q;

  always_comb begin
    logic [VW-1:0] base;
    logic signed [PW:0] bs, dl, sm;
    logic up, en;
    base = '0;
    bs = '0;
    dl = '0;
    sm = '0;
    up = 1'b0;
    en = 1'b0;
    for (int l = 0; l < NL; l++) begin
      case (l)
        LN_S1:   base = i_side_q.ctx.v1;
        LN_S2:   base = i_side_q.ctx.v2;
        LN_M1:   base = i_side_q.ctx.p1;
        default: base = i_side_q.ctx.p2;
      endcase
      up = (l == LN_S1) || (l == LN_M1);
      en = (l == LN_S1 || l == LN_S2) ? i_side_q.va : i_side_q.pa;
      for (int i = 0; i < 3; i++) begin
        bs = sx(base, i);
        dl = i_prod_q[l][i] >>> FB;
        sm = up ? bs + dl : bs - dl;
        j_vec_d[l][i*CB +: CB] = en ? sat_c(sm) : base[i*CB +: CB];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j_vec_q <= j_vec_d;
      j_va_q  <= i_side_q.va;
      j_pa_q  <= i_side_q.pa;
    end
  end

  // Valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
      j_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      i_vld_q <= div_vld;
      j_vld_q <= i_vld_q;
    end
  end

  // ---------------- Output register
  logic o_vld_q, o_load;
  logic [VW-1:0] o_vec_q [NL];
  logic o_va_q, o_pa_q;

  // Hold everything only when the last stage cannot drain
  assign adv        = !(j_vld_q && o_vld_q && out_stall_i);
  assign in_stall_o = !adv;
  assign o_load     = j_vld_q && (!o_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (o_load) begin
      o_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_vec_q <= j_vec_q;
      o_va_q  <= j_va_q;
      o_pa_q  <= j_pa_q;
    end
  end

  assign out_valid_o        = o_vld_q;
  assign new_vel_first_o    = OVW'(o_vec_q[LN_S1]);
  assign new_vel_second_o   = OVW'(o_vec_q[LN_S2]);
  assign new_pos_first_o    = OVW'(o_vec_q[LN_M1]);
  assign new_pos_second_o   = OVW'(o_vec_q[LN_M2]);
  assign velocity_applied_o = o_va_q;
  assign position_applied_o = o_pa_q;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;
  import pcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [OVW-1:0] v1, v2, a1, a2, p1, p2, n;
    logic [IMW-1:0] im1, im2;
    logic [PENW-1:0] pen;
    logic [RW-1:0] rest;
    logic has2;
  } contact_t;

  typedef struct {
    logic [OVW-1:0] v1, v2, p1, p2;
    logic va, pa;
  } resolved_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [TSW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OVW-1:0] vel_first_i = '0, vel_second_i = '0, acc_first_i = '0, acc_second_i = '0;
  logic [OVW-1:0] pos_first_i = '0, pos_second_i = '0, normal_i = '0;
  logic [IMW-1:0] inv_mass_first_i = '0, inv_mass_second_i = '0;
  logic signed [PENW-1:0] penetration_i = '0;
  logic [RW-1:0] restitution_i = '0;
  logic has_second_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OVW-1:0] new_vel_first_o, new_vel_second_o, new_pos_first_o, new_pos_second_o;
  logic velocity_applied_o, position_applied_o;

  int errors = 0;
  int cycles = 0;
  int hold_left = 0;

  particle_contact_resolver_top uut (.*);

  always #6 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  class contact_scoreboard;
    logic [TSW-1:0] time_step = TS_RESET;
    resolved_t pending[$];

    function longint comp(input logic [OVW-1:0] w, input int i);
      return longint'($signed(w[i*CB +: CB]));
    endfunction

    function logic [CB-1:0] clamp(input longint x);
      longint lim;
      lim = (longint'(1) << (CB - 1)) - 1;
      if (x > lim) x = lim;
      if (x < -lim - 1) x = -lim - 1;
      return x[CB-1:0];
    endfunction

    // Work out the resolved contact from one accepted transaction
    function void note(input contact_t c);
      resolved_t r;
      longint v1[3], v2[3], a1[3], a2[3], p1[3], p2[3], n[3];
      longint sep, accd, acc20, target, dv36, pen, rest;
      longint unsigned im1, im2, total, dv10, s1, s2, m1, m2;
      for (int i = 0; i < 3; i++) begin
        v1[i] = comp(c.v1, i); v2[i] = comp(c.v2, i);
        a1[i] = comp(c.a1, i); a2[i] = comp(c.a2, i);
        p1[i] = comp(c.p1, i); p2[i] = comp(c.p2, i);
        n[i] = comp(c.n, i);
      end
      im1 = c.im1;
      im2 = c.has2 ? c.im2 : 0;
      total = im1 + im2;
      pen = longint'($signed(c.pen));
      rest = c.rest;
      sep = 0;
      accd = 0;
      for (int i = 0; i < 3; i++) begin
        sep += (v1[i] - (c.has2 ? v2[i] : 0)) * n[i];
        accd += (a1[i] - (c.has2 ? a2[i] : 0)) * n[i];
      end
      r.va = (sep < 0) && (total != 0);
      if (r.va) begin
        acc20 = (accd * longint'(time_step)) >>> 16;
        target = -sep * rest;
        if (acc20 < 0) begin
          target += rest * acc20;
          if (target < 0) target = 0;
        end
        dv36 = target - sep * 65536;
        dv10 = longint'(unsigned'(dv36)) >> 26;
        s1 = dv10 * im1 / total;
        s2 = dv10 * im2 / total;
        for (int i = 0; i < 3; i++) begin
          v1[i] = v1[i] + ((longint'(s1) * n[i]) >>> FB);
          v2[i] = v2[i] - ((longint'(s2) * n[i]) >>> FB);
        end
      end
      r.pa = (pen > 0) && (total != 0);
      if (r.pa) begin
        m1 = longint'(pen) * im1 / total;
        m2 = longint'(pen) * im2 / total;
        for (int i = 0; i < 3; i++) begin
          p1[i] = p1[i] + ((longint'(m1) * n[i]) >>> FB);
          p2[i] = p2[i] - ((longint'(m2) * n[i]) >>> FB);
        end
      end
      for (int i = 0; i < 3; i++) begin
        r.v1[i*CB +: CB] = clamp(v1[i]);
        r.v2[i*CB +: CB] = clamp(v2[i]);
        r.p1[i*CB +: CB] = clamp(p1[i]);
        r.p2[i*CB +: CB] = clamp(p2[i]);
      end
      pending.push_back(r);
    endfunction

    // Compare a result transaction with the oldest expectation
    task check(input resolved_t got);
      resolved_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.v1 !== e.v1) report($sformatf("new_vel_first %h exp %h", got.v1, e.v1));
      if (got.v2 !== e.v2) report($sformatf("new_vel_second %h exp %h", got.v2, e.v2));
      if (got.p1 !== e.p1) report($sformatf("new_pos_first %h exp %h", got.p1, e.p1));
      if (got.p2 !== e.p2) report($sformatf("new_pos_second %h exp %h", got.p2, e.p2));
      if (got.va !== e.va) report($sformatf("velocity_applied %b exp %b", got.va, e.va));
      if (got.pa !== e.pa) report($sformatf("position_applied %b exp %b", got.pa, e.pa));
    endtask
  endclass

  contact_scoreboard sb = new();

  // Random component: mostly modest values, sometimes anything
  function automatic logic [CB-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(CB-1){1'b1}}};
      1: return {1'b1, {(CB-1){1'b0}}};
      2, 3: return CB'($urandom);
      default: return CB'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic logic [OVW-1:0] rand_vec();
    return {rand_comp(), rand_comp(), rand_comp()};
  endfunction

  // Normal: usually near unit length along a signed axis, sometimes arbitrary
  function automatic logic [OVW-1:0] rand_normal();
    logic [CB-1:0] c[3];
    int ax;
    if ($urandom_range(0, 4) == 0) return rand_vec();
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++)
      c[i] = (i == ax) ? CB'($urandom_range(0, 1) ? 1024 : -1024)
                       : CB'(int'($urandom_range(0, 600)) - 300);
    return {c[2], c[1], c[0]};
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    c.v1 = rand_vec(); c.v2 = rand_vec();
    c.a1 = rand_vec(); c.a2 = rand_vec();
    c.p1 = rand_vec(); c.p2 = rand_vec();
    c.n = rand_normal();
    c.im1 = ($urandom_range(0, 7) == 0) ? '0 : IMW'($urandom);
    c.im2 = ($urandom_range(0, 7) == 0) ? '0 : IMW'($urandom);
    c.pen = ($urandom_range(0, 2) == 0) ? PENW'($urandom) : PENW'($urandom_range(0, 4096));
    c.rest = ($urandom_range(0, 5) == 0) ? RW'($urandom) : RW'($urandom_range(0, 65536));
    c.has2 = $urandom_range(0, 3) != 0;
    return c;
  endfunction

  // Offer one transaction from a falling edge and hold it until taken
  task automatic drive_contact(input contact_t c);
    in_valid_i = 1'b1;
    vel_first_i = c.v1; vel_second_i = c.v2;
    acc_first_i = c.a1; acc_second_i = c.a2;
    pos_first_i = c.p1; pos_second_i = c.p2;
    normal_i = c.n;
    inv_mass_first_i = c.im1; inv_mass_second_i = c.im2;
    penetration_i = c.pen; restitution_i = c.rest;
    has_second_i = c.has2;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(c);
    @(negedge clk_i);
  endtask

  // Drain the block, then write time_step
  task automatic write_time_step(input logic [TSW-1:0] val);
    in_valid_i = 1'b0;
    wait (sb.pending.size() == 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.time_step = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(input int count);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i = 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk_i);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      drive_contact(rand_contact());
    end
    in_valid_i = 1'b0;
  endtask

  // Receiver stall pattern, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      case ((cycles / 97) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= ((cycles % 8) < 2);
      endcase
    end
  end

  // Sample results at the rising edge
  always @(posedge clk_i) begin
    resolved_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.v1 = new_vel_first_o; got.v2 = new_vel_second_o;
      got.p1 = new_pos_first_o; got.p2 = new_pos_second_o;
      got.va = velocity_applied_o; got.pa = position_applied_o;
      sb.check(got);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    contact_t c;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed contacts under the reset time step
    for (int k = 0; k < 22; k++) begin
      c = rand_contact();
      c.n = {21'd0, 21'd0, 21'd1024};
      c.v1 = {21'd0, 21'd0, CB'(-2048)};
      c.v2 = '0;
      c.has2 = 1'b1;
      c.im1 = 24'h010000; c.im2 = 24'h010000;
      c.pen = 21'd512;
      c.rest = 17'd32768;
      case (k)
        0: begin c.im1 = '0; c.im2 = '0; end                 // immovable pair
        1: begin c.im1 = '0; c.has2 = 1'b0; end              // immovable against scenery
        2: c.v1 = {21'd0, 21'd0, 21'd2048};                  // separating
        3: c.v1 = '0;                                        // touching
        4: c.pen = '0;
        5: c.pen = 21'h100000;                               // most negative depth
        6: c.pen = 21'h0FFFFF;
        7: c.rest = 17'h1FFFF;                               // restitution near two
        8: c.rest = 17'd65536;
        9: c.rest = '0;
        10: begin c.has2 = 1'b0; c.v2 = '1; c.p2 = '1; end
        11: c.n = rand_vec();                                // non-unit normal
        12: begin c.v1 = {3{21'h100000}}; c.n = {3{21'h0FFFFF}}; end
        13: begin c.v1 = {3{21'h0FFFFF}}; c.n = {3{21'h100000}}; end
        14: begin c.im1 = '1; c.im2 = '1; end
        15: begin c.im1 = 24'd1; c.im2 = '1; end
        16: c.a1 = {21'd0, 21'd0, 21'h100000};               // strong closing acceleration
        17: c.a1 = {21'd0, 21'd0, 21'h0FFFFF};
        18: begin c.p1 = {3{21'h0FFFFF}}; c.pen = 21'h0FFFFF; end
        19: begin c.p2 = {3{21'h100000}}; c.pen = 21'h0FFFFF; end
        20: begin c.v1 = '1; c.v2 = '1; c.a1 = '1; c.a2 = '1; c.n = '1; end
        default: begin c.v1 = '0; c.a1 = '0; c.p1 = '0; c.n = '0; end
      endcase
      drive_contact(c);
    end
    in_valid_i = 1'b0;

    // Random phases across time step settings
    write_time_step(16'd0);
    run_random(120);
    write_time_step(16'hFFFF);
    hold_left = HOLD_CYCLES;
    run_random(220);
    in_valid_i = 1'b0;
    wait (sb.pending.size() == 0);
    @(negedge clk_i);
    run_random(120);
    write_time_step(16'd1);
    run_random(120);
    write_time_step(16'($urandom));
    hold_left = HOLD_CYCLES;
    run_random(200);

    wait (sb.pending.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
